FILE: rtl/core/cmbd_pkg.sv
// shared constants, codes and types for the console memory bus decoder
`timescale 1ns / 1ps

package cmbd_pkg;

    // store sizes in bytes, each a power of two
    localparam int RAM_BYTES  = 2097152;
    localparam int ROM_BYTES  = 524288;
    localparam int PAGE_BYTES = 65536;

    // one byte-wide memory holds every store: ram, expansion, local io, rom
    localparam int MEM_BYTES = RAM_BYTES + 2 * PAGE_BYTES + ROM_BYTES;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int CLR_BYTES = RAM_BYTES + 2 * PAGE_BYTES;

    localparam logic [MEM_AW-1:0] RAM_BASE = MEM_AW'(0);
    localparam logic [MEM_AW-1:0] EXP_BASE = MEM_AW'(RAM_BYTES);
    localparam logic [MEM_AW-1:0] LIO_BASE = MEM_AW'(RAM_BYTES + PAGE_BYTES);
    localparam logic [MEM_AW-1:0] ROM_BASE = MEM_AW'(RAM_BYTES + 2 * PAGE_BYTES);
    localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(CLR_BYTES - 1);

    localparam logic [MEM_AW-1:0] RAM_MASK  = MEM_AW'(RAM_BYTES - 1);
    localparam logic [MEM_AW-1:0] PAGE_MASK = MEM_AW'(PAGE_BYTES - 1);
    localparam logic [MEM_AW-1:0] ROM_MASK  = MEM_AW'(ROM_BYTES - 1);

    // address map
    localparam logic [15:0] PAGE_LIO    = 16'h1f80;
    localparam logic [15:0] PAGE_BYTEIO = 16'h1f40;
    localparam logic [15:0] PAGE_EXP    = 16'h1f00;
    localparam logic [15:0] PAGE_ROM0   = 16'hbfc0;
    localparam logic [15:0] PAGE_RAMCTL = 16'h1d00;
    localparam logic [15:0] PAGE_RAMEND = 16'h0080;
    localparam logic [15:0] ROM_PAGES   = 16'((ROM_BYTES + 65535) / 65536);
    localparam logic [8:0]  RAM_SEG_K0  = 9'h100;
    localparam logic [8:0]  RAM_SEG_K1  = 9'h140;
    localparam logic [31:0] FWD_MASK    = 32'hf000_1000;

    // ram write control data words
    localparam logic [31:0] RAMCTL_OFF_A = 32'h0000_0800;
    localparam logic [31:0] RAMCTL_OFF_B = 32'h0000_0804;
    localparam logic [31:0] RAMCTL_ON    = 32'h0001_e988;

    // access kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;

    // access sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    // result targets
    localparam logic [2:0] TGT_RAM  = 3'd0;
    localparam logic [2:0] TGT_EXP  = 3'd1;
    localparam logic [2:0] TGT_LIO  = 3'd2;
    localparam logic [2:0] TGT_ROM  = 3'd3;
    localparam logic [2:0] TGT_FWD  = 3'd4;
    localparam logic [2:0] TGT_NONE = 3'd5;

    // decoded access handed from the decoder to the engine
    typedef struct packed {
        logic [2:0]        target;
        logic              wr;
        logic              done;
        logic              ram_wr_en;
        logic [2:0]        nbytes;
        logic [MEM_AW-1:0] base;
        logic [MEM_AW-1:0] off;
        logic [MEM_AW-1:0] mask;
    } dec_t;

    // one result item
    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  target;
        logic        write_done;
        logic        ram_writable;
    } res_t;

endpackage

FILE: rtl/core/console_memory_bus_decoder.sv
// top level of the console memory bus decoder
`timescale 1ns / 1ps

// Decodes one bus access per transfer against a console memory map: mirrored
// main ram, an expansion page, a local io page, a boot rom, hardware forwarding
// and unmapped space. All stores share one byte-wide synchronous memory that is
// accessed one byte per cycle; forwarded, unmapped or dropped accesses touch
// no bytes. The next item is accepted once the sequencer is back in idle. After
// reset the ram, expansion and local io regions are swept to zero, one byte per
// cycle; no transfer is accepted during the sweep. Rom contents are undefined
// until loaded. A result register lets a new item start while the previous
// result waits on the master side.
module console_memory_bus_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // access_size[1:0], address[33:2], write_data[65:34], cache_isolated[66]
    input  logic [71:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[31:0], write_done[32], ram_writable[33]
    output logic [39:0] m_axis_tdata,
    // target[2:0]
    output logic [2:0]  m_axis_tuser
);

    cmbd_pkg::dec_t dec;
    cmbd_pkg::res_t res;
    cmbd_pkg::res_t out_reg;
    logic           ram_we_reg;
    logic           out_vld_reg;
    logic           eng_idle;
    logic           res_valid;
    logic           res_ready;
    logic           start;

    assign s_axis_tready = eng_idle;
    assign start         = s_axis_tvalid && eng_idle;

    cmbd_decode u_decode
    (
        .kind           (s_axis_tuser),
        .access_size    (s_axis_tdata[1:0]),
        .address        (s_axis_tdata[33:2]),
        .write_data     (s_axis_tdata[65:34]),
        .cache_isolated (s_axis_tdata[66]),
        .ram_allowed    (ram_we_reg),
        .dec            (dec)
    );

    cmbd_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dec       (dec),
        .wdata     (s_axis_tdata[65:34]),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // ram write enable flag, updated as each transfer is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_we_reg <= 1'b1;
        end
        else if (start)
        begin
            ram_we_reg <= dec.ram_wr_en;
        end
    end

    // result register
    assign res_ready = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_vld_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'd0, out_reg.ram_writable, out_reg.write_done, out_reg.read_data};
    assign m_axis_tuser  = out_reg.target;

endmodule

FILE: rtl/core/cmbd_decode.sv
// address decode and write policy for one bus access
`timescale 1ns / 1ps

module cmbd_decode
(
    input  logic [1:0]        kind,
    input  logic [1:0]        access_size,
    input  logic [31:0]       address,
    input  logic [31:0]       write_data,
    input  logic              cache_isolated,
    input  logic              ram_allowed,
    output cmbd_pkg::dec_t    dec
);

    logic [15:0]                 page;
    logic [15:0]                 rom_page;
    logic [31:0]                 ram_raw;
    logic [31:0]                 rom_raw;
    logic [2:0]                  nbytes;
    logic                        is_word;
    logic                        is_ram;
    logic                        is_rom;
    logic [2:0]                  map_tgt;
    logic                        map_store;
    logic [cmbd_pkg::MEM_AW-1:0] map_base;
    logic [cmbd_pkg::MEM_AW-1:0] map_off;
    logic [cmbd_pkg::MEM_AW-1:0] map_mask;
    logic                        wr_ok;

    assign page     = address[31:16];
    assign rom_page = page - cmbd_pkg::PAGE_ROM0;
    assign ram_raw  = {9'd0, page[6:0], address[15:0]};
    assign rom_raw  = {rom_page, address[15:0]};

    // size code three behaves as a word
    always_comb
    begin
        case (access_size)
            cmbd_pkg::SZ_BYTE: nbytes = 3'd1;
            cmbd_pkg::SZ_HALF: nbytes = 3'd2;
            default:           nbytes = 3'd4;
        endcase
    end

    assign is_word = (access_size != cmbd_pkg::SZ_BYTE) && (access_size != cmbd_pkg::SZ_HALF);

    assign is_ram = (page < cmbd_pkg::PAGE_RAMEND) ||
                    (page[15:7] == cmbd_pkg::RAM_SEG_K0) ||
                    (page[15:7] == cmbd_pkg::RAM_SEG_K1);
    assign is_rom = (page >= cmbd_pkg::PAGE_ROM0) &&
                    (page < cmbd_pkg::PAGE_ROM0 + cmbd_pkg::ROM_PAGES);

    // region map
    always_comb
    begin
        map_tgt   = cmbd_pkg::TGT_NONE;
        map_store = 1'b0;
        map_base  = cmbd_pkg::RAM_BASE;
        map_off   = '0;
        map_mask  = '0;
        if (page == cmbd_pkg::PAGE_LIO)
        begin
            if ((address & cmbd_pkg::FWD_MASK) != 32'd0)
            begin
                map_tgt = cmbd_pkg::TGT_FWD;
            end
            else
            begin
                map_tgt   = cmbd_pkg::TGT_LIO;
                map_store = 1'b1;
                map_base  = cmbd_pkg::LIO_BASE;
                map_off   = cmbd_pkg::MEM_AW'(address[15:0]) & cmbd_pkg::PAGE_MASK;
                map_mask  = cmbd_pkg::PAGE_MASK;
            end
        end
        else if (page == cmbd_pkg::PAGE_BYTEIO)
        begin
            map_tgt = (access_size == cmbd_pkg::SZ_BYTE) ? cmbd_pkg::TGT_FWD
                                                         : cmbd_pkg::TGT_NONE;
        end
        else if (is_ram)
        begin
            map_tgt   = cmbd_pkg::TGT_RAM;
            map_store = 1'b1;
            map_base  = cmbd_pkg::RAM_BASE;
            map_off   = cmbd_pkg::MEM_AW'(ram_raw) & cmbd_pkg::RAM_MASK;
            map_mask  = cmbd_pkg::RAM_MASK;
        end
        else if (page == cmbd_pkg::PAGE_EXP)
        begin
            map_tgt   = cmbd_pkg::TGT_EXP;
            map_store = 1'b1;
            map_base  = cmbd_pkg::EXP_BASE;
            map_off   = cmbd_pkg::MEM_AW'(address[15:0]) & cmbd_pkg::PAGE_MASK;
            map_mask  = cmbd_pkg::PAGE_MASK;
        end
        else if (is_rom)
        begin
            map_tgt   = cmbd_pkg::TGT_ROM;
            map_store = 1'b1;
            map_base  = cmbd_pkg::ROM_BASE;
            map_off   = cmbd_pkg::MEM_AW'(rom_raw) & cmbd_pkg::ROM_MASK;
            map_mask  = cmbd_pkg::ROM_MASK;
        end
    end

    // write policy per region
    always_comb
    begin
        case (map_tgt)
            cmbd_pkg::TGT_RAM: wr_ok = ram_allowed &&
                                       ((access_size == cmbd_pkg::SZ_BYTE) || !cache_isolated);
            cmbd_pkg::TGT_EXP: wr_ok = (access_size == cmbd_pkg::SZ_BYTE) || !cache_isolated;
            cmbd_pkg::TGT_LIO: wr_ok = 1'b1;
            default:           wr_ok = 1'b0;
        endcase
    end

    // per kind outcome
    always_comb
    begin
        dec           = '0;
        dec.target    = cmbd_pkg::TGT_NONE;
        dec.ram_wr_en = ram_allowed;
        unique case (kind)
            cmbd_pkg::KIND_READ:
            begin
                dec.target = map_tgt;
                dec.base   = map_base;
                dec.off    = map_off;
                dec.mask   = map_mask;
                dec.nbytes = map_store ? nbytes : 3'd0;
            end
            cmbd_pkg::KIND_WRITE:
            begin
                dec.target = map_tgt;
                dec.base   = map_base;
                dec.off    = map_off;
                dec.mask   = map_mask;
                dec.wr     = 1'b1;
                dec.done   = wr_ok && map_store;
                dec.nbytes = (wr_ok && map_store) ? nbytes : 3'd0;
                // ram write enable control words
                if (is_word && (page == cmbd_pkg::PAGE_RAMCTL))
                begin
                    if ((write_data == cmbd_pkg::RAMCTL_OFF_A) ||
                        (write_data == cmbd_pkg::RAMCTL_OFF_B))
                    begin
                        dec.ram_wr_en = 1'b0;
                    end
                    else if (write_data == cmbd_pkg::RAMCTL_ON)
                    begin
                        dec.ram_wr_en = 1'b1;
                    end
                end
            end
            cmbd_pkg::KIND_LOAD:
            begin
                dec.target = cmbd_pkg::TGT_ROM;
                dec.base   = cmbd_pkg::ROM_BASE;
                dec.off    = cmbd_pkg::MEM_AW'(address) & cmbd_pkg::ROM_MASK;
                dec.mask   = cmbd_pkg::ROM_MASK;
                dec.wr     = 1'b1;
                dec.done   = 1'b1;
                dec.nbytes = 3'd1;
            end
            default:
            begin
                dec.target = cmbd_pkg::TGT_NONE;
            end
        endcase
    end

endmodule

FILE: rtl/core/cmbd_engine.sv
// byte-serial memory sequencer with the shared storage and the clearing pass
`timescale 1ns / 1ps

module cmbd_engine
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cmbd_pkg::dec_t    dec,
    input  logic [31:0]       wdata,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_ready,
    output cmbd_pkg::res_t    res
);

    typedef enum logic [3:0]
    {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    cmbd_pkg::dec_t              item_reg, item_next;
    logic [31:0]                 wdata_reg, wdata_next;
    logic [31:0]                 rdata_reg, rdata_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic                        cap_reg, cap_next;
    logic [1:0]                  lane_reg, lane_next;
    logic [cmbd_pkg::MEM_AW-1:0] clr_reg, clr_next;

    logic [7:0]                  mem [cmbd_pkg::MEM_BYTES];
    logic [7:0]                  mem_q;
    logic                        mem_we;
    logic [cmbd_pkg::MEM_AW-1:0] mem_idx;
    logic [7:0]                  mem_wd;
    logic                        issue;
    logic [cmbd_pkg::MEM_AW-1:0] byte_off;
    logic [31:0]                 wshift;

    // byte address of the current lane, wrapped inside its store
    assign byte_off = (item_reg.off + cmbd_pkg::MEM_AW'(cnt_reg)) & item_reg.mask;
    assign wshift   = wdata_reg >> {cnt_reg[1:0], 3'b000};
    assign issue    = (state_reg == ST_RUN) && (cnt_reg < item_reg.nbytes);

    // memory port: one byte a cycle, registered read
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we  = 1'b1;
            mem_idx = clr_reg;
            mem_wd  = 8'd0;
        end
        else
        begin
            mem_we  = issue && item_reg.wr;
            mem_idx = item_reg.base + byte_off;
            mem_wd  = wshift[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_idx] <= mem_wd;
        end
        mem_q <= mem[mem_idx];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        wdata_next = wdata_reg;
        rdata_next = rdata_reg;
        cnt_next   = cnt_reg;
        cap_next   = 1'b0;
        lane_next  = lane_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + cmbd_pkg::MEM_AW'(1);
                if (clr_reg == cmbd_pkg::CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = dec;
                    wdata_next = wdata;
                    rdata_next = 32'd0;
                    cnt_next   = 3'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    cnt_next  = cnt_reg + 3'd1;
                    cap_next  = !item_reg.wr;
                    lane_next = cnt_reg[1:0];
                end
                // merge the byte read in the previous cycle
                if (cap_reg)
                begin
                    rdata_next = rdata_reg | ({24'd0, mem_q} << {lane_reg, 3'b000});
                end
                if (!issue && !cap_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= 3'd0;
            cap_reg   <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cap_reg   <= cap_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        wdata_reg <= wdata_next;
        rdata_reg <= rdata_next;
        lane_reg  <= lane_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FIN);

    always_comb
    begin
        res.read_data    = rdata_reg;
        res.target       = item_reg.target;
        res.write_done   = item_reg.done;
        res.ram_writable = item_reg.ram_wr_en;
    end

endmodule

FILE: rtl/core/cmbd_checker.sv
// port-level checks on the console memory bus decoder, bound to the top level
`timescale 1ns / 1ps

module cmbd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [71:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // target code stays within the map
    a_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= cmbd_pkg::TGT_NONE))
        else $error("result target out of range");

    // only local stores report a completed write
    a_done_local: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[32]) |->
        (m_axis_tuser != cmbd_pkg::TGT_FWD && m_axis_tuser != cmbd_pkg::TGT_NONE))
        else $error("write done on a forwarded or unmapped access");

    // forwarded and unmapped accesses read zero
    a_zero_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == cmbd_pkg::TGT_FWD ||
                           m_axis_tuser == cmbd_pkg::TGT_NONE)) |->
        (m_axis_tdata[31:0] == 32'd0))
        else $error("nonzero read data on a forwarded or unmapped access");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind console_memory_bus_decoder cmbd_checker u_cmbd_checker (.*);
